FILE: hw/rtl/sng_pkg.sv
// Shared types, register codes and sphere offset tables for the sphere
// neighborhood address generator. No dependencies.
package sng_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_RADIUS     = 3'd0;
    localparam logic [2:0] REG_WIDTH_X    = 3'd1;
    localparam logic [2:0] REG_HEIGHT_Y   = 3'd2;
    localparam logic [2:0] REG_DEPTH_Z    = 3'd3;
    localparam logic [2:0] REG_PLANE_SIZE = 3'd4;

    // Radius codes
    localparam logic [1:0] RADIUS_0 = 2'd0;
    localparam logic [1:0] RADIUS_1 = 2'd1;

    // Points per sphere: 1, 7 and 33
    localparam int R1_POINTS = 7;
    localparam int R2_POINTS = 33;

    // Offsets packed as {dx, dy, dz}, 3-bit two's complement each (one octal digit),
    // listed x outer, y middle, z inner.
    localparam logic [8:0] R1_OFFSETS [R1_POINTS] = '{
        9'o700, 9'o070, 9'o007, 9'o000, 9'o001, 9'o010, 9'o100
    };

    localparam logic [8:0] R2_OFFSETS [R2_POINTS] = '{
        9'o600,
        9'o777, 9'o770, 9'o771, 9'o707, 9'o700, 9'o701, 9'o717, 9'o710, 9'o711,
        9'o060, 9'o077, 9'o070, 9'o071, 9'o006, 9'o007, 9'o000, 9'o001, 9'o002,
        9'o017, 9'o010, 9'o011, 9'o020,
        9'o177, 9'o170, 9'o171, 9'o107, 9'o100, 9'o101, 9'o117, 9'o110, 9'o111,
        9'o200
    };

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [1:0]  radius;
        logic [10:0] width_x;
        logic [10:0] height_y;
        logic [10:0] depth_z;
        logic [20:0] plane_size;
    } cfg_t;

    // One sphere point issued by the sequencer
    typedef struct packed {
        logic [9:0] cx;
        logic [9:0] cy;
        logic [9:0] cz;
        logic [5:0] idx;
        logic [1:0] r;
        logic       last;
    } point_t;

    // Index of the final point for a given radius
    function automatic logic [5:0] last_index(input logic [1:0] r);
        logic [5:0] res;
        case (r)
            RADIUS_0: res = 6'd0;
            RADIUS_1: res = 6'(R1_POINTS - 1);
            default:  res = 6'(R2_POINTS - 1);
        endcase
        return res;
    endfunction

    // Offset of point k on the sphere of radius r
    function automatic logic [8:0] point_offset(input logic [1:0] r, input logic [5:0] k);
        logic [8:0] res;
        case (r)
            RADIUS_0: res = 9'o000;
            RADIUS_1: res = (k < 6'(R1_POINTS)) ? R1_OFFSETS[k[2:0]] : 9'o000;
            default:  res = (k < 6'(R2_POINTS)) ? R2_OFFSETS[k] : 9'o000;
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/sng_apb_regs.sv
// APB-style configuration registers for the sphere address generator.
// Depends on sng_pkg for register codes and the cfg_t struct.
module sng_apb_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sng_pkg::cfg_t     cfg
);

    logic [1:0]  radius_reg;
    logic [10:0] width_x_reg;
    logic [10:0] height_y_reg;
    logic [10:0] depth_z_reg;
    logic [20:0] plane_size_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Write on the access cycle; unknown indexes drop the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= 2'd1;
            width_x_reg    <= 11'd256;
            height_y_reg   <= 11'd256;
            depth_z_reg    <= 11'd256;
            plane_size_reg <= 21'd65536;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sng_pkg::REG_RADIUS:     radius_reg     <= pwdata[1:0];
                sng_pkg::REG_WIDTH_X:    width_x_reg    <= pwdata[10:0];
                sng_pkg::REG_HEIGHT_Y:   height_y_reg   <= pwdata[10:0];
                sng_pkg::REG_DEPTH_Z:    depth_z_reg    <= pwdata[10:0];
                sng_pkg::REG_PLANE_SIZE: plane_size_reg <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            sng_pkg::REG_RADIUS:     prdata = 32'(radius_reg);
            sng_pkg::REG_WIDTH_X:    prdata = 32'(width_x_reg);
            sng_pkg::REG_HEIGHT_Y:   prdata = 32'(height_y_reg);
            sng_pkg::REG_DEPTH_Z:    prdata = 32'(depth_z_reg);
            sng_pkg::REG_PLANE_SIZE: prdata = 32'(plane_size_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.radius     = radius_reg;
    assign cfg.width_x    = width_x_reg;
    assign cfg.height_y   = height_y_reg;
    assign cfg.depth_z    = depth_z_reg;
    assign cfg.plane_size = plane_size_reg;

endmodule

FILE: hw/rtl/sng_seq.sv
// Point sequencer: latches one center and issues one sphere point per cycle while adv is high.
// Depends on sng_pkg for point_t, cfg_t and the point count table.
module sng_seq #(
    parameter int MAX_RADIUS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [9:0]        center_x,
    input  logic [9:0]        center_y,
    input  logic [9:0]        center_z,
    input  sng_pkg::cfg_t     cfg,
    input  logic              adv,
    output logic              pt_valid,
    output sng_pkg::point_t   pt
);

    localparam logic [1:0] MaxR = 2'(MAX_RADIUS);

    logic       busy_reg;
    logic       busy_next;
    logic [5:0] k_reg;
    logic [5:0] k_next;
    logic [1:0] r_reg;
    logic [9:0] cx_reg;
    logic [9:0] cy_reg;
    logic [9:0] cz_reg;
    logic       last;
    logic       accept;
    logic [1:0] r_eff;

    assign last     = (k_reg == sng_pkg::last_index(r_reg));
    // Take the next center in the same cycle the final point moves on
    assign in_stall = busy_reg && !(adv && last);
    assign accept   = in_valid && !in_stall;
    assign r_eff    = (cfg.radius > MaxR) ? MaxR : cfg.radius;

    // Advance the point counter
    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            k_next    = 6'd0;
        end
        else if (adv && busy_reg)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    // Hold the center for the whole sphere
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            cz_reg <= center_z;
            r_reg  <= r_eff;
        end
    end

    assign pt_valid = busy_reg;
    assign pt.cx    = cx_reg;
    assign pt.cy    = cy_reg;
    assign pt.cz    = cz_reg;
    assign pt.idx   = k_reg;
    assign pt.r     = r_reg;
    assign pt.last  = last;

`ifndef SYNTH
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (k_reg <= sng_pkg::last_index(r_reg)))
        else $error("point counter past end of sphere");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && adv && last && !accept) |=> !busy_reg)
        else $error("sequencer stays busy after final point");

    a_accept_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && k_reg == 6'd0))
        else $error("new center does not start at first point");
`endif

endmodule

FILE: hw/rtl/sng_addr_pipe.sv
// Three-stage address pipeline: offset add, bounds check and multiply, final sum.
// Depends on sng_pkg for point_t, cfg_t and the offset tables.
module sng_addr_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  sng_pkg::cfg_t     cfg,
    input  logic              pt_valid,
    input  sng_pkg::point_t   pt,
    output logic              adv,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [29:0]       voxel_address,
    output logic              out_of_volume,
    output logic [5:0]        point_index,
    output logic              is_last
);

    // Stage 1: neighbor coordinates
    logic              s1_valid_reg;
    logic signed [11:0] s1_x_reg;
    logic signed [11:0] s1_y_reg;
    logic signed [11:0] s1_z_reg;
    logic [5:0]        s1_idx_reg;
    logic              s1_last_reg;
    logic [8:0]        offs;
    logic signed [11:0] s1_x_next;
    logic signed [11:0] s1_y_next;
    logic signed [11:0] s1_z_next;

    // Stage 2: products and bounds flag
    logic              s2_valid_reg;
    logic [31:0]       s2_pz_reg;
    logic [21:0]       s2_py_reg;
    logic [10:0]       s2_x_reg;
    logic              s2_oov_reg;
    logic [5:0]        s2_idx_reg;
    logic              s2_last_reg;
    logic [31:0]       s2_pz_next;
    logic [21:0]       s2_py_next;
    logic              s2_oov_next;

    // Stage 3: output register
    logic              out_valid_reg;
    logic [29:0]       addr_reg;
    logic              oov_reg;
    logic [5:0]        idx_reg;
    logic              last_reg;
    logic [29:0]       addr_next;

    // Whole pipe moves unless the result waits on the receiver
    assign adv = !(out_valid_reg && out_stall);

    // Add the table offset to the center
    always_comb
    begin
        offs      = sng_pkg::point_offset(pt.r, pt.idx);
        s1_x_next = $signed({2'b00, pt.cx}) + $signed({{9{offs[8]}}, offs[8:6]});
        s1_y_next = $signed({2'b00, pt.cy}) + $signed({{9{offs[5]}}, offs[5:3]});
        s1_z_next = $signed({2'b00, pt.cz}) + $signed({{9{offs[2]}}, offs[2:0]});
    end

    // Check bounds and form the plane and row products
    always_comb
    begin
        s2_oov_next = s1_x_reg[11] || (s1_x_reg[10:0] >= cfg.width_x)
                   || s1_y_reg[11] || (s1_y_reg[10:0] >= cfg.height_y)
                   || s1_z_reg[11] || (s1_z_reg[10:0] >= cfg.depth_z);
        s2_pz_next  = 32'(cfg.plane_size) * 32'(s1_z_reg[10:0]);
        s2_py_next  = 22'(cfg.width_x) * 22'(s1_y_reg[10:0]);
    end

    // Sum and wrap to the address width; out-of-volume points give address zero
    assign addr_next = s2_oov_reg ? 30'd0
                     : 30'(s2_pz_reg) + 30'(s2_py_reg) + 30'(s2_x_reg);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pt_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= s1_x_next;
            s1_y_reg    <= s1_y_next;
            s1_z_reg    <= s1_z_next;
            s1_idx_reg  <= pt.idx;
            s1_last_reg <= pt.last;

            s2_pz_reg   <= s2_pz_next;
            s2_py_reg   <= s2_py_next;
            s2_x_reg    <= s1_x_reg[10:0];
            s2_oov_reg  <= s2_oov_next;
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;

            addr_reg    <= addr_next;
            oov_reg     <= s2_oov_reg;
            idx_reg     <= s2_idx_reg;
            last_reg    <= s2_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign voxel_address = addr_reg;
    assign out_of_volume = oov_reg;
    assign point_index   = idx_reg;
    assign is_last       = last_reg;

`ifndef SYNTH
    a_oov_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_volume) |-> (voxel_address == 30'd0))
        else $error("out-of-volume result carries nonzero address");

    a_s2_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg) |=> out_valid_reg)
        else $error("stage 2 item lost on the way out");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (point_index <= 6'(sng_pkg::R2_POINTS - 1)))
        else $error("point index beyond largest sphere");
`endif

endmodule

FILE: hw/rtl/sphere_neighborhood_address_gen.sv
// Top level of the sphere neighborhood address generator.
// Depends on sng_pkg, sng_apb_regs, sng_seq and sng_addr_pipe.
//
// Usage:
// - Input channel (in_valid / in_stall, center_x/y/z) takes one center voxel per
//   transfer. Output channel (out_valid / out_stall) gives one result per sphere
//   point: voxel_address, out_of_volume, point_index and is_last on the final one.
// - A center yields 1, 7 or 33 points for radius 0, 1 or 2 (radius is clamped to
//   MAX_RADIUS). The sequencer issues one point per cycle while out_stall does not
//   hold the pipe; the next center is taken in the cycle the final point of the
//   previous one moves on, with no gap.
// - Each point passes the sequencer registers, then the offset add, bounds check and
//   multiply and final sum stages before its result is valid.
// - When out_stall is high with a valid result, the whole pipe and the sequencer
//   hold; nothing is dropped or repeated; in_stall rises if the sequencer is busy.
// - Reset clears all valid bits and loads radius 1, 256 x 256 x 256 volume,
//   plane size 65536. Write the APB registers (byte address 4 * index) only
//   while no center is in flight.
module sphere_neighborhood_address_gen #(
    parameter int MAX_RADIUS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  center_x,
    input  logic [9:0]  center_y,
    input  logic [9:0]  center_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [29:0] voxel_address,
    output logic        out_of_volume,
    output logic [5:0]  point_index,
    output logic        is_last
);

    sng_pkg::cfg_t   cfg;
    sng_pkg::point_t pt;
    logic            pt_valid;
    logic            adv;

    // Configuration registers
    sng_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Point sequencer
    sng_seq #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .center_x (center_x),
        .center_y (center_y),
        .center_z (center_z),
        .cfg      (cfg),
        .adv      (adv),
        .pt_valid (pt_valid),
        .pt       (pt)
    );

    // Address pipeline
    sng_addr_pipe u_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .pt_valid      (pt_valid),
        .pt            (pt),
        .adv           (adv),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .voxel_address (voxel_address),
        .out_of_volume (out_of_volume),
        .point_index   (point_index),
        .is_last       (is_last)
    );

endmodule
